// ----- src/ohs_pkg.sv -----
// Shared types and constants for the open-addressing hash set.
// Holds word layouts, operation and status codes, controller states and
// the command/status structs. No dependencies.
package ohs_pkg;

    // Default sizing
    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_KEY_WIDTH = 64;

    // Field widths of the request and response words
    localparam int KIND_W   = 2;
    localparam int KEY_IN_W = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 10;
    localparam int LIMIT_W  = 10;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_FILL_LIMIT   = 1'b0;
    localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = 10'd896;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [KEY_IN_W-1:0] key;
    } req_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_word_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_SWEEP,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic                load;
        logic                rd;
        logic                adv;
        logic                wr_key;
        logic                sweep;
        logic                cnt_inc;
        logic                cnt_clr;
        logic                set_res;
        logic [STATUS_W-1:0] res_status;
        logic                res_slot_en;
        logic                out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic below_limit;
        logic is_insert;
        logic out_free;
    } sts_t;

endpackage

// ----- src/ohs_ctrl.sv -----
// Controller state machine for the hash set: sequences sweeps, probes,
// inserts and result hand-off. Depends on ohs_pkg.
module ohs_ctrl
    import ohs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [KIND_W-1:0] req_kind,
    output logic              req_stall,
    input  sts_t              sts,
    output cmd_t              cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            // Empty every slot once after reset
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (req_kind == KIND_CLEAR)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            // Decide on the slot just read
            S_CHECK:
            begin
                if (sts.slot_empty)
                begin
                    if (sts.is_insert && sts.below_limit)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = sts.is_insert ? ST_FULL : ST_MISS;
                        state_next     = S_DONE;
                    end
                end
                else if (sts.slot_match)
                begin
                    cmd.set_res     = 1'b1;
                    cmd.res_slot_en = 1'b1;
                    cmd.res_status  = sts.is_insert ? ST_PRESENT : ST_HIT;
                    state_next      = S_DONE;
                end
                else if (sts.probe_last)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = sts.is_insert ? ST_FULL : ST_MISS;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                cmd.wr_key      = 1'b1;
                cmd.cnt_inc     = 1'b1;
                cmd.set_res     = 1'b1;
                cmd.res_slot_en = 1'b1;
                cmd.res_status  = ST_INSERTED;
                state_next      = S_DONE;
            end
            // Clear operation: empty every slot, then drop the count
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.cnt_clr    = 1'b1;
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_CLEARED;
                    state_next     = S_DONE;
                end
            end
            // Hold the result until the output register is free
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

// ----- src/ohs_dp.sv -----
// Datapath for the hash set: slot memory, probe address and stride,
// entry count, result and output registers. Depends on ohs_pkg.
module ohs_dp
    import ohs_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  req_word_t          req,
    input  logic [LIMIT_W-1:0] fill_limit,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_word_t          rsp
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = AW + 1;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Slot memory: valid bit above the key
    logic [KEY_WIDTH:0] mem [CAPACITY];
    logic [KEY_WIDTH:0] rdata_reg;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic [KEY_WIDTH:0] mem_wdata;

    logic [KEY_WIDTH-1:0] key_in;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 insert_reg;
    logic [AW-1:0]        pos_reg;
    logic [AW-1:0]        stride_reg;
    logic [AW-1:0]        probe_n_reg;
    logic [AW-1:0]        sweep_addr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [AW-1:0]        res_slot_reg;
    logic                 out_valid_reg;
    rsp_word_t            out_word_reg;

    assign key_in = req.key[KEY_WIDTH-1:0];

    // Memory port: sweep writes empty slots, insert writes the key
    assign mem_addr  = cmd.sweep ? sweep_addr_reg : pos_reg;
    assign mem_we    = cmd.sweep | cmd.wr_key;
    assign mem_wdata = cmd.sweep ? '0 : {1'b1, key_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Load the key and start of the probe, advance by the odd stride
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg     <= key_in;
            insert_reg  <= (req.kind == KIND_INSERT);
            pos_reg     <= AW'(key_in);
            stride_reg  <= AW'({key_in, 1'b1});
            probe_n_reg <= '0;
        end
        else if (cmd.adv)
        begin
            pos_reg     <= pos_reg + stride_reg;
            probe_n_reg <= probe_n_reg + 1'b1;
        end
    end

    // Sweep address and entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cmd.sweep)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Hold the result until the output register is free
    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= cmd.res_slot_en ? pos_reg : '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word_reg.status      <= res_status_reg;
            out_word_reg.slot        <= SLOT_W'(res_slot_reg);
            out_word_reg.entry_count <= COUNT_W'(count_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

    // Status to the controller
    assign sts.sweep_last  = &sweep_addr_reg;
    assign sts.slot_empty  = ~rdata_reg[KEY_WIDTH];
    assign sts.slot_match  = (rdata_reg[KEY_WIDTH-1:0] == key_reg);
    assign sts.probe_last  = &probe_n_reg;
    assign sts.below_limit = CMP_W'(count_reg) < CMP_W'(fill_limit);
    assign sts.is_insert   = insert_reg;
    assign sts.out_free    = ~out_valid_reg | ~rsp_stall;

endmodule

// ----- src/open_addressing_hash_set.sv -----
// Open-addressing hash set of keys with a fill_limit register on an APB port.
// Top level: register port, controller and datapath. Depends on ohs_pkg,
// ohs_ctrl and ohs_dp.
//
// A set of up to CAPACITY keys of KEY_WIDTH bits. A request word carries a
// lookup, an insert or a clear; each gives exactly one response word. The
// probe starts at key mod CAPACITY and steps by 2*key+1, one read of the
// single-port slot memory per probe, and reads at most CAPACITY slots. An
// insert that stores the key adds a write after the last read. A clear
// walks the memory one slot a cycle. A finished response waits while the
// previous word is still held in the output register by rsp_stall. After
// reset the same clearing pass runs before the first request is taken;
// register writes are accepted throughout. One request is in work at a
// time; the next is taken once the finished response is loaded into the
// output register, where it may still wait on rsp_stall.
module open_addressing_hash_set
    import ohs_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_word_t          req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_word_t          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0]   fill_limit_reg;
    logic [PADDR_W-3:0]   reg_index;
    cmd_t                 cmd;
    sts_t                 sts;

    // Register port
    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_limit_reg <= FILL_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && (reg_index == REG_FILL_LIMIT))
        begin
            fill_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (reg_index == REG_FILL_LIMIT) ? PDATA_W'(fill_limit_reg) : '0;

    ohs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ohs_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .fill_limit (fill_limit_reg),
        .cmd        (cmd),
        .sts        (sts),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

`ifndef SYNTHESIS
    // An accepted request keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in work");

    // A response only appears after the controller loads it
    a_rsp_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.out_load))
        else $error("response raised without a load");

    // A clear leaves an empty table and no slot
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_CLEARED) |-> (rsp.entry_count == '0) && (rsp.slot == '0))
        else $error("clear response with entries left");

    // Miss and full carry no slot
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp.status == ST_MISS) || (rsp.status == ST_FULL)) |-> (rsp.slot == '0))
        else $error("slot given for miss or full");
`endif

endmodule
